// File: rtl/lru_ordered_key_table_core_defines.svh
// assertion macros shared by the table core
`ifndef LRU_ORDERED_KEY_TABLE_CORE_DEFINES_SVH
`define LRU_ORDERED_KEY_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked on every edge out of reset
`define LOKT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LOKT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lokt_pkg.sv
// shared types and codes of the recency-ordered key table
package lokt_pkg;

    localparam int KEY_W  = 64;
    localparam int TIME_W = 48;
    localparam int SIZE_W = 32;
    localparam int STAT_W = 3;
    localparam int OCC_W  = 7;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_EVICT  = 2'd3
    } t_op;

    localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd1;
    localparam logic [STAT_W-1:0] ST_NEW      = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    typedef enum logic [1:0] {
        UPD_NONE   = 2'd0,
        UPD_MOVE   = 2'd1,
        UPD_DROP   = 2'd2,
        UPD_INSERT = 2'd3
    } t_upd;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic             cmp_en;
        logic             head_sel;
        logic [KEY_W-1:0] key;
        t_upd             mode;
        t_entry           new_entry;
        t_entry           hit_entry;
    } t_cell_ctl;

endpackage

// File: rtl/lokt_cell.sv
// one position of the recency chain: entry storage, key compare, shift toward head
module lokt_cell
    import lokt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_head,
    input  logic      i_prev_valid,
    input  logic      i_next_valid,
    input  t_entry    i_next_entry,
    input  logic      i_after,
    output logic      o_after,
    output logic      o_valid,
    output logic      o_match,
    output t_entry    o_entry
);

    logic   r_valid;
    logic   r_match;
    t_entry r_entry;
    logic   w_after;

    // set from the hit position onward
    assign w_after = i_after | r_match;
    assign o_after = w_after;
    assign o_valid = r_valid;
    assign o_match = r_match;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp_en) begin
                r_match <= r_valid & (i_ctl.head_sel ? i_head : (r_entry.key == i_ctl.key));
            end
            unique case (i_ctl.mode)
                UPD_DROP: begin
                    if (w_after && r_valid && !i_next_valid) begin
                        r_valid <= 1'b0;
                    end
                end
                UPD_INSERT: begin
                    if (!r_valid && i_prev_valid) begin
                        r_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.mode)
            UPD_MOVE: begin
                if (w_after && r_valid) begin
                    r_entry <= i_next_valid ? i_next_entry : i_ctl.hit_entry;
                end
            end
            UPD_DROP: begin
                if (w_after && r_valid && i_next_valid) begin
                    r_entry <= i_next_entry;
                end
            end
            UPD_INSERT: begin
                if (!r_valid && i_prev_valid) begin
                    r_entry <= i_ctl.new_entry;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/lru_ordered_key_table_core.sv
// top level of the recency-ordered key table: cell chain, sequencer, output register
//
//   channel   direction   valid        stall         payload
//   in        sink        i_in_valid   o_in_stall    i_operation i_key i_access_time i_object_size
//   out       source      o_out_valid  i_out_stall   o_status o_entry_key o_entry_time
//                                                    o_entry_size o_occupancy
//
// an input beat passes through capture, compare in every cell,
// hit reduction, then the chain update that also loads the output register
// the update waits while a previous result is still stalled in the output register
// o_in_stall is high from capture until the update is committed
// synchronous active-low reset empties the chain; no clearing pass is needed
// cell 0 holds the oldest entry; entries always sit packed from cell 0 upward
`include "lru_ordered_key_table_core_defines.svh"

module lru_ordered_key_table_core
    import lokt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [TIME_W-1:0] i_access_time,
    input  logic [SIZE_W-1:0] i_object_size,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [STAT_W-1:0] o_status,
    output logic [KEY_W-1:0]  o_entry_key,
    output logic [TIME_W-1:0] o_entry_time,
    output logic [SIZE_W-1:0] o_entry_size,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_FND,
        S_UPD
    } t_state;

    t_state r_state;

    // captured input beat
    t_op    r_op;
    t_entry r_item;

    // hit reduction result
    logic   r_found;
    t_entry r_hit;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // output register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    t_entry            r_out_entry;
    logic [OCC_W-1:0]  r_out_occ;

    // cell chain wiring
    t_cell_ctl             w_ctl;
    logic [CAPACITY-1:0]   w_valid;
    logic [CAPACITY-1:0]   w_match;
    logic [CAPACITY:0]     w_after;
    t_entry                w_entry [CAPACITY];
    t_entry                w_hit_or;

    // decision of the update cycle
    logic              w_commit;
    t_upd              w_mode;
    logic [STAT_W-1:0] w_status;
    t_entry            w_res;

    assign w_after[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lokt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_head       (g == 0),
            .i_prev_valid ((g == 0) ? 1'b1 : w_valid[(g == 0) ? 0 : g - 1]),
            .i_next_valid ((g == CAPACITY - 1) ? 1'b0 : w_valid[(g == CAPACITY - 1) ? g : g + 1]),
            .i_next_entry ((g == CAPACITY - 1) ? '0 : w_entry[(g == CAPACITY - 1) ? g : g + 1]),
            .i_after      (w_after[g]),
            .o_after      (w_after[g+1]),
            .o_valid      (w_valid[g]),
            .o_match      (w_match[g]),
            .o_entry      (w_entry[g])
        );
    end

    // keys are unique, so at most one cell matches and an or-reduction picks it
    always_comb begin
        w_hit_or = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_or = w_hit_or | (w_match[i] ? w_entry[i] : '0);
        end
    end

    // update decision, one result per beat
    always_comb begin
        w_commit = (r_state == S_UPD) && (!r_out_valid || !i_out_stall);
        w_mode   = UPD_NONE;
        w_status = ST_HIT;
        w_res    = r_hit;
        n_count  = r_count;
        unique case (r_op)
            OP_ACCESS: begin
                if (r_found) begin
                    w_mode = UPD_MOVE;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    w_status = ST_FULL;
                    w_res    = '0;
                end else begin
                    w_mode   = UPD_INSERT;
                    w_status = ST_NEW;
                    w_res    = r_item;
                    n_count  = r_count + 1'b1;
                end
            end
            OP_GET: begin
                if (!r_found) begin
                    w_status = ST_NOTFOUND;
                    w_res    = '0;
                end
            end
            OP_REMOVE, OP_EVICT: begin
                if (r_found) begin
                    w_mode  = UPD_DROP;
                    n_count = r_count - 1'b1;
                end else begin
                    w_status = (r_op == OP_EVICT) ? ST_EMPTY : ST_NOTFOUND;
                    w_res    = '0;
                end
            end
            default: begin
            end
        endcase
        if (!w_commit) begin
            w_mode  = UPD_NONE;
            n_count = r_count;
        end
    end

    always_comb begin
        w_ctl.cmp_en    = (r_state == S_CMP);
        w_ctl.head_sel  = (r_op == OP_EVICT);
        w_ctl.key       = r_item.key;
        w_ctl.mode      = w_mode;
        w_ctl.new_entry = r_item;
        w_ctl.hit_entry = r_hit;
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result loads, a stalled one holds, a taken one drains
            r_out_valid <= w_commit | (r_out_valid & i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_FND;
                end
                S_FND: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                        r_count <= n_count;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_op         <= t_op'(i_operation);
            r_item.key   <= i_key;
            r_item.stamp <= i_access_time;
            r_item.size  <= i_object_size;
        end
        if (r_state == S_FND) begin
            r_found <= |w_match;
            r_hit   <= w_hit_or;
        end
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_entry  <= w_res;
            r_out_occ    <= OCC_W'(n_count);
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_entry_key  = r_out_entry.key;
    assign o_entry_time = r_out_entry.stamp;
    assign o_entry_size = r_out_entry.size;
    assign o_occupancy  = r_out_occ;

    // entries stay packed toward the head
    `LOKT_ASSERT_NOW(a_packed, 1'b1, (((w_valid >> 1) & ~w_valid) == '0), "chain has a gap")
    // the count tracks the cells that hold an entry
    `LOKT_ASSERT_NOW(a_count, 1'b1, ($countones(w_valid) == r_count), "count out of step")
    // unique keys give at most one matching cell
    `LOKT_ASSERT_NOW(a_one_hit, (r_state == S_FND), $onehot0(w_match), "several cells hit")
    // a stalled result is never dropped
    `LOKT_ASSERT_NEXT(a_out_hold, (r_out_valid && i_out_stall), r_out_valid, "result lost")

endmodule

// File: bench/tb.sv
// self-checking bench for the recency-ordered key table: directed rows, then random phases
module tb;
    import lokt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH   = 64;
    localparam int KEY_POOL_SIZE = 72;   // a few more keys than slots so the table can fill
    localparam int RANDOM_BEATS  = 450;
    localparam int IDLE_LIMIT    = 1000; // cycles with no beat on either channel
    localparam int DRAIN_CYCLES  = 8;    // settle time after the last owed result, before the verdict

    localparam logic [KEY_W-1:0]  K_ONES = {KEY_W{1'b1}};
    localparam logic [TIME_W-1:0] T_ONES = {TIME_W{1'b1}};
    localparam logic [SIZE_W-1:0] S_ONES = {SIZE_W{1'b1}};
    localparam logic [KEY_W-1:0]  KEY_A  = 64'h0123_4567_89ab_cdef;
    localparam logic [KEY_W-1:0]  KEY_B  = 64'h8000_0000_0000_0001;
    localparam logic [KEY_W-1:0]  KEY_C  = 64'h5555_aaaa_5555_aaaa;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
        logic [SIZE_W-1:0] nbytes;
    } t_lru_entry;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_lru_entry        entry;
        logic [OCC_W-1:0]  occ;
    } t_table_result;

    // one row of the directed part; want is used only where fixed is set
    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
        logic [SIZE_W-1:0] nbytes;
        logic              fixed;
        t_table_result     want;
    } t_directed_row;

    typedef enum {PH_FILL, PH_MIX, PH_DRAIN} t_phase;

    localparam t_table_result NO_RESULT = '0;
    localparam t_lru_entry    NO_ENTRY  = '0;

    localparam int DIRECTED_COUNT = 23;
    localparam t_directed_row DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // empty table: every lookup misses, evict reports empty
        '{OP_EVICT,  64'h0, T_ONES, S_ONES, 1'b1, '{ST_EMPTY,    NO_ENTRY, 7'd0}},
        '{OP_GET,    64'h0, T_ONES, S_ONES, 1'b1, '{ST_NOTFOUND, NO_ENTRY, 7'd0}},
        '{OP_REMOVE, K_ONES, 48'h0, 32'h0,  1'b1, '{ST_NOTFOUND, NO_ENTRY, 7'd0}},
        // extreme keys, stamps and sizes
        '{OP_ACCESS, 64'h0, 48'h0, 32'h0, 1'b1,
            '{ST_NEW, '{64'h0, 48'h0, 32'h0}, 7'd1}},
        '{OP_ACCESS, K_ONES, T_ONES, S_ONES, 1'b1,
            '{ST_NEW, '{K_ONES, T_ONES, S_ONES}, 7'd2}},
        // a hit keeps the stored stamp and size, not the beat's
        '{OP_ACCESS, 64'h0, T_ONES, S_ONES, 1'b1,
            '{ST_HIT, '{64'h0, 48'h0, 32'h0}, 7'd2}},
        '{OP_GET, K_ONES, 48'h0, 32'h0, 1'b1,
            '{ST_HIT, '{K_ONES, T_ONES, S_ONES}, 7'd2}},
        // hit on the oldest, then on the newest
        '{OP_ACCESS, K_ONES, 48'h1, 32'h1, 1'b0, NO_RESULT},
        '{OP_ACCESS, K_ONES, 48'h5, 32'h5, 1'b0, NO_RESULT},
        // evict ignores key, stamp and size
        '{OP_EVICT,  K_ONES, T_ONES, S_ONES, 1'b0, NO_RESULT},
        '{OP_REMOVE, K_ONES, 48'h0, 32'h0, 1'b0, NO_RESULT},
        '{OP_REMOVE, K_ONES, 48'h0, 32'h0, 1'b1, '{ST_NOTFOUND, NO_ENTRY, 7'd0}},
        // three entries, unlink from the middle and from both ends
        '{OP_ACCESS, KEY_A, 48'h8000_0000_0001, 32'h8000_0001, 1'b0, NO_RESULT},
        '{OP_ACCESS, KEY_B, 48'h7fff_ffff_fffe, 32'h7fff_fffe, 1'b0, NO_RESULT},
        '{OP_ACCESS, KEY_C, 48'h5555_5555_5555, 32'haaaa_aaaa, 1'b0, NO_RESULT},
        '{OP_REMOVE, KEY_B, T_ONES, S_ONES, 1'b0, NO_RESULT},
        '{OP_ACCESS, KEY_A, T_ONES, S_ONES, 1'b0, NO_RESULT},
        '{OP_GET,    KEY_C, T_ONES, S_ONES, 1'b0, NO_RESULT},
        '{OP_REMOVE, KEY_A, 48'h0, 32'h0, 1'b0, NO_RESULT},
        // reinsert into a freed slot, then drain to empty
        '{OP_ACCESS, KEY_B, 48'h1234_5678_9abc, 32'h0bad_f00d, 1'b0, NO_RESULT},
        '{OP_EVICT,  KEY_A, 48'h0, 32'h0, 1'b0, NO_RESULT},
        '{OP_EVICT,  64'h0, 48'h0, 32'h0, 1'b0, NO_RESULT},
        '{OP_EVICT,  64'h0, 48'h0, 32'h0, 1'b1, '{ST_EMPTY, NO_ENTRY, 7'd0}}
    };

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_in_valid    = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_operation   = OP_ACCESS;
    logic [KEY_W-1:0]  i_key         = '0;
    logic [TIME_W-1:0] i_access_time = '0;
    logic [SIZE_W-1:0] i_object_size = '0;
    logic              o_out_valid;
    logic              i_out_stall   = 1'b0;
    logic [STAT_W-1:0] o_status;
    logic [KEY_W-1:0]  o_entry_key;
    logic [TIME_W-1:0] o_entry_time;
    logic [SIZE_W-1:0] o_entry_size;
    logic [OCC_W-1:0]  o_occupancy;

    // predicted contents, oldest first, and results still owed by the block
    t_lru_entry    lru_order [$];
    t_table_result pending_results [$];
    t_table_result head_result;

    logic [KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  idle_cycles    = 0;
    int  burst_left     = 0;
    bit  valid_held     = 1'b0;  // what the last drive of i_in_valid was
    bit  rx_stalling    = 1'b0;
    int  rx_run_left    = 0;

    lru_ordered_key_table_core #(
        .CAPACITY(TABLE_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_key        (i_key),
        .i_access_time(i_access_time),
        .i_object_size(i_object_size),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_entry_key  (o_entry_key),
        .o_entry_time (o_entry_time),
        .o_entry_size (o_entry_size),
        .o_occupancy  (o_occupancy)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // apply one operation to the predicted table and return the result it should give
    function automatic t_table_result apply_table_op(t_op op, logic [KEY_W-1:0] key,
                                                     logic [TIME_W-1:0] stamp,
                                                     logic [SIZE_W-1:0] nbytes);
        t_table_result res;
        t_lru_entry    hit;
        int            where;
        res   = '0;
        where = -1;
        foreach (lru_order[i]) begin
            if (lru_order[i].key == key) where = i;
        end
        case (op)
            OP_ACCESS: begin
                if (where >= 0) begin
                    // present key moves to newest, stored fields kept
                    hit = lru_order[where];
                    lru_order.delete(where);
                    lru_order.push_back(hit);
                    res.status = ST_HIT;
                    res.entry  = hit;
                end else if (lru_order.size() >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    hit = '{key, stamp, nbytes};
                    lru_order.push_back(hit);
                    res.status = ST_NEW;
                    res.entry  = hit;
                end
            end
            OP_GET: begin
                if (where >= 0) begin
                    res.status = ST_HIT;
                    res.entry  = lru_order[where];
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            OP_REMOVE: begin
                if (where >= 0) begin
                    res.status = ST_HIT;
                    res.entry  = lru_order[where];
                    lru_order.delete(where);
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            default: begin
                if (lru_order.size() == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = ST_HIT;
                    res.entry  = lru_order.pop_front();
                end
            end
        endcase
        res.occ = OCC_W'(lru_order.size());
        return res;
    endfunction

    // mostly keys from the pool so hits happen, sometimes a key never seen
    function automatic logic [KEY_W-1:0] pooled_or_fresh_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(string field, logic [KEY_W-1:0] got,
                                   logic [KEY_W-1:0] want);
        $display("mismatch in %s of result %0d: got %h, expected %h",
                 field, results_seen, got, want);
        mismatch_count++;
    endtask

    // drive one input beat, hold it until taken, then record what it should produce
    task automatic send_beat(t_op op, logic [KEY_W-1:0] key, logic [TIME_W-1:0] stamp,
                             logic [SIZE_W-1:0] nbytes, logic fixed, t_table_result want);
        t_table_result predicted;
        i_in_valid    <= 1'b1;
        valid_held     = 1'b1;
        i_operation   <= op;
        i_key         <= key;
        i_access_time <= stamp;
        i_object_size <= nbytes;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = apply_table_op(op, key, stamp, nbytes);
        pending_results.push_back(fixed ? want : predicted);
        // bursts of random length, now and then a long one with no gaps at all
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 10);
            i_in_valid <= 1'b0;
            valid_held  = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // hold off the sender until every owed result has come out
    task automatic wait_for_results();
        if (valid_held) begin
            i_in_valid <= 1'b0;
            valid_held  = 1'b0;
        end
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: alternating runs of stalls and free cycles, sometimes a long free stretch
    always @(posedge i_clk) begin
        if (rx_run_left == 0) begin
            rx_stalling = !rx_stalling;
            if (rx_stalling) begin
                rx_run_left = $urandom_range(1, ($urandom_range(0, 5) == 0) ? 16 : 4);
            end else begin
                rx_run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                          : $urandom_range(1, 12);
            end
        end else begin
            rx_run_left--;
        end
        i_out_stall <= rx_stalling;
    end

    // result checker: every output beat against the oldest owed result
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing owed, key", o_entry_key, '0);
            end else begin
                head_result = pending_results.pop_front();
                if (o_status !== head_result.status)
                    report_mismatch("status", o_status, head_result.status);
                if (o_entry_key !== head_result.entry.key)
                    report_mismatch("entry_key", o_entry_key, head_result.entry.key);
                if (o_entry_time !== head_result.entry.stamp)
                    report_mismatch("entry_time", o_entry_time, head_result.entry.stamp);
                if (o_entry_size !== head_result.entry.nbytes)
                    report_mismatch("entry_size", o_entry_size, head_result.entry.nbytes);
                if (o_occupancy !== head_result.occ)
                    report_mismatch("occupancy", o_occupancy, head_result.occ);
            end
        end
    end

    // watchdog: too long with no beat on either channel means the block hung
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results owed",
                     idle_cycles, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int               random_sent;
        int               phase_len;
        int               walk;
        int               pick;
        bit               first_phase;
        t_phase           phase;
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [63:0]      wide;

        random_sent = 0;
        walk        = 0;
        first_phase = 1'b1;
        key_pool[0] = '0;
        key_pool[1] = K_ONES;
        for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows
        foreach (DIRECTED_ROWS[r]) begin
            send_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].stamp,
                      DIRECTED_ROWS[r].nbytes, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].want);
        end
        wait_for_results();

        // random phases: fill walks the pool so the table overflows, mix exercises
        // every operation, drain empties the table through evict and remove
        while (random_sent < RANDOM_BEATS) begin
            phase       = first_phase ? PH_FILL : t_phase'($urandom_range(0, 2));
            first_phase = 1'b0;
            case (phase)
                PH_FILL:  phase_len = 80;
                PH_MIX:   phase_len = $urandom_range(20, 60);
                default:  phase_len = $urandom_range(20, 70);
            endcase
            for (int n = 0; n < phase_len && random_sent < RANDOM_BEATS; n++) begin
                pick = $urandom_range(0, 99);
                case (phase)
                    PH_FILL: begin
                        op  = (pick < 90) ? OP_ACCESS : OP_GET;
                        key = (pick % 10 == 0) ? pooled_or_fresh_key()
                                               : key_pool[walk % KEY_POOL_SIZE];
                        walk++;
                    end
                    PH_MIX: begin
                        op  = (pick < 50) ? OP_ACCESS : (pick < 70) ? OP_GET
                            : (pick < 85) ? OP_REMOVE : OP_EVICT;
                        key = pooled_or_fresh_key();
                    end
                    default: begin
                        op  = (pick < 55) ? OP_EVICT : (pick < 85) ? OP_REMOVE : OP_GET;
                        key = pooled_or_fresh_key();
                    end
                endcase
                wide = {$urandom, $urandom};
                send_beat(op, key, wide[TIME_W-1:0], $urandom, 1'b0, NO_RESULT);
                random_sent++;
            end
            if ($urandom_range(0, 3) == 0) wait_for_results();
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/lokt_pkg.sv
rtl/lokt_cell.sv
rtl/lru_ordered_key_table_core.sv
bench/tb.sv
